FILE: rtl/csvt_pkg.sv
// Shared types and constants of the CSV cell tokenizer.
package csvt_pkg;

   // Byte values with a fixed meaning
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] LINE_END_RESET = 8'd13;

   // Default column count; the column index itself is always 8 bits
   localparam int unsigned MAX_COLUMNS_DEFAULT = 256;
   localparam int unsigned COL_W = 8;

   // Quote tracking state
   typedef enum logic [1:0] {
      MODE_UNQUOTED = 2'd0,
      MODE_QUOTED   = 2'd1,
      MODE_PENDING  = 2'd2
   } quote_mode_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_CHAR     = 2'd0,
      KIND_CELL_END = 2'd1,
      KIND_ROW_END  = 2'd2
   } kind_type;

   // Parser state carried from byte to byte
   typedef struct packed {
      quote_mode_type     mode;
      logic [COL_W-1:0]   column;
      logic               row_open;
   } parse_state_type;

   // One result item
   typedef struct packed {
      kind_type           kind;
      logic [7:0]         data_byte;
      logic [COL_W-1:0]   column_index;
      logic               last_of_run;
   } result_type;

endpackage

FILE: rtl/csvt_step.sv
// Per-byte parsing logic: next parser state and up to two result items.
module csvt_step
   import csvt_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEFAULT
) (
   input  parse_state_type  cur_st,
   input  logic [7:0]       line_end_char,
   input  logic [7:0]       byte_in,
   input  logic             end_of_text,
   output parse_state_type  next_st,
   output result_type       res0,
   output result_type       res1,
   output logic [1:0]       res_count
);

   // Highest column reachable: smaller of MAX_COLUMNS-1 and 255
   localparam int unsigned ColLimitInt = (MAX_COLUMNS - 1 > 255) ? 255 : (MAX_COLUMNS - 1);
   localparam logic [COL_W-1:0] ColLimit = COL_W'(ColLimitInt);

   logic             is_quote;
   logic             is_comma;
   logic             is_line_end;
   logic [COL_W-1:0] col_inc;
   parse_state_type  mid_st;
   result_type       r0;
   result_type       r1;
   logic             r0_valid;
   logic             r1_valid;

   assign is_quote    = (byte_in == CHAR_QUOTE);
   assign is_comma    = (byte_in == CHAR_COMMA);
   assign is_line_end = (byte_in == line_end_char);
   assign col_inc     = (cur_st.column < ColLimit) ? cur_st.column + COL_W'(1) : cur_st.column;

   // Next state after the byte itself, before end-of-text handling
   always_comb begin
      mid_st = cur_st;
      if (cur_st.mode == MODE_PENDING && is_quote) begin
         mid_st.mode     = MODE_QUOTED;
         mid_st.row_open = 1'b1;
      end else if (cur_st.mode == MODE_QUOTED) begin
         if (is_quote) begin
            mid_st.mode = end_of_text ? MODE_UNQUOTED : MODE_PENDING;
         end
         mid_st.row_open = 1'b1;
      end else begin
         mid_st.mode = MODE_UNQUOTED;
         if (is_quote) begin
            mid_st.mode     = MODE_QUOTED;
            mid_st.row_open = 1'b1;
         end else if (is_comma) begin
            mid_st.column   = col_inc;
            mid_st.row_open = 1'b1;
         end else if (is_line_end) begin
            mid_st.column   = '0;
            mid_st.row_open = 1'b0;
         end else begin
            mid_st.row_open = 1'b1;
         end
      end
   end

   // End of text puts the parser back to its start state
   always_comb begin
      next_st = mid_st;
      if (end_of_text) begin
         next_st.mode     = MODE_UNQUOTED;
         next_st.column   = '0;
         next_st.row_open = 1'b0;
      end
   end

   // Result items
   always_comb begin
      r0_valid        = 1'b0;
      r0.kind         = KIND_CHAR;
      r0.data_byte    = '0;
      r0.column_index = cur_st.column;
      if (cur_st.mode == MODE_PENDING && is_quote) begin
         r0_valid     = 1'b1;
         r0.data_byte = CHAR_QUOTE;
      end else if (cur_st.mode == MODE_QUOTED) begin
         if (!is_quote) begin
            r0_valid     = 1'b1;
            r0.data_byte = byte_in;
         end
      end else if (!is_quote) begin
         r0_valid = 1'b1;
         if (is_comma) begin
            r0.kind = KIND_CELL_END;
         end else if (is_line_end) begin
            r0.kind = KIND_ROW_END;
         end else begin
            r0.data_byte = byte_in;
         end
      end

      // open row closed at the end of the text
      r1_valid        = end_of_text && mid_st.row_open;
      r1.kind         = KIND_ROW_END;
      r1.data_byte    = '0;
      r1.column_index = mid_st.column;
      r1.last_of_run  = 1'b1;
      r0.last_of_run  = !r1_valid;
   end

   // Pack valid results to the front
   assign res0      = r0_valid ? r0 : r1;
   assign res1      = r1;
   assign res_count = {1'b0, r0_valid} + {1'b0, r1_valid};

endmodule

FILE: rtl/csv_cell_tokenizer_unit.sv
// Top level of the CSV cell tokenizer: input register, parser state, result queue.
//
// Usage
//   req_*  : one CSV text byte per item; req_tlast marks the last byte of a text.
//   rsp_*  : result items; rsp_tuser is the kind (char, cell end, row end),
//            rsp_tdata carries the character and the column, rsp_tlast marks
//            the final result caused by one input byte.
//   csr_*  : write of the line-end byte, taken whenever csr_wr_en is high;
//            write it only while no item is in flight.
// An accepted item is held in the input register and parsed from there into
// a two-entry result queue, from which its first result is offered.
// Throughput: one byte per cycle while the receiver takes every result and
// each byte gives at most one result; a byte that gives two results (row
// closed at end of text) occupies the result port for both and can hold
// the input back. An opening quote, or a quote that closes a quoted cell,
// gives none. The rate is set by the result queue: a byte is parsed only
// when the queue has room for all its results, which keeps req_tready free
// of rsp_tready.
// Reset: synchronous; clears the parser state, empties the queue and loads
// the line-end byte with carriage return. When the receiver stalls the queue
// fills, the input register holds its byte and req_tready drops.
module csv_cell_tokenizer_unit
   import csvt_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // configuration
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data,     // line_end_char
   // byte input
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,       // [7:0] byte_in
   input  logic         req_tlast,       // end_of_text
   // results
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,       // [7:0] data_byte, [15:8] column_index
   output logic [1:0]   rsp_tuser,       // [1:0] kind
   output logic         rsp_tlast        // last_of_run
);

   // input register
   logic             in_valid_ff, in_valid_in;
   logic [7:0]       byte_ff;
   logic             eot_ff;
   // configuration register
   logic [7:0]       line_end_ff;
   // parser state
   parse_state_type  state_ff, state_in;
   // result queue
   result_type       q_ff [2];
   logic             head_ff, head_in;
   logic [1:0]       cnt_ff, cnt_in;

   parse_state_type  step_next;
   result_type       res0, res1;
   logic [1:0]       res_count;
   logic             process;
   logic             req_fire;
   logic             rsp_fire;
   logic             wr0_idx, wr1_idx;

   csvt_step #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_step (
      .cur_st        (state_ff),
      .line_end_char (line_end_ff),
      .byte_in       (byte_ff),
      .end_of_text   (eot_ff),
      .next_st       (step_next),
      .res0          (res0),
      .res1          (res1),
      .res_count     (res_count)
   );

   // Parse the held byte when the queue has room for all its results
   assign process    = in_valid_ff && (({1'b0, cnt_ff} + {1'b0, res_count}) <= 3'd2);
   assign req_tready = !in_valid_ff || process;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   assign in_valid_in = req_fire ? 1'b1 : (process ? 1'b0 : in_valid_ff);
   assign state_in    = process ? step_next : state_ff;

   // Queue pointers
   assign wr0_idx = head_ff + cnt_ff[0];
   assign wr1_idx = wr0_idx + 1'b1;
   assign head_in = rsp_fire ? head_ff + 1'b1 : head_ff;
   assign cnt_in  = cnt_ff + (process ? res_count : 2'd0) - {1'b0, rsp_fire};

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '{mode: MODE_UNQUOTED, column: '0, row_open: 1'b0};
         head_ff     <= 1'b0;
         cnt_ff      <= 2'd0;
         line_end_ff <= LINE_END_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         head_ff     <= head_in;
         cnt_ff      <= cnt_in;
         if (csr_wr_en) begin
            line_end_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         byte_ff <= req_tdata;
         eot_ff  <= req_tlast;
      end
      if (process && res_count != 2'd0) begin
         q_ff[wr0_idx] <= res0;
      end
      if (process && res_count == 2'd2) begin
         q_ff[wr1_idx] <= res1;
      end
   end

   // Result port
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {q_ff[head_ff].column_index, q_ff[head_ff].data_byte};
   assign rsp_tuser  = q_ff[head_ff].kind;
   assign rsp_tlast  = q_ff[head_ff].last_of_run;

   // Checks
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("result queue overfilled");

   a_eot_restart : assert property (@(posedge clock) disable iff (reset)
      process && eot_ff |=> state_ff.mode == MODE_UNQUOTED && state_ff.column == '0
                            && !state_ff.row_open)
      else $error("parser not back at start after end of text");

   a_mode_legal : assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == MODE_UNQUOTED || state_ff.mode == MODE_QUOTED
      || state_ff.mode == MODE_PENDING)
      else $error("illegal quote mode");

   a_pending_no_eot : assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == MODE_PENDING |-> state_ff.row_open)
      else $error("pending quote outside an open row");

endmodule

FILE: tb/csv_cell_tokenizer_unit_tb.sv
// Self-checking testbench of the CSV cell tokenizer: directed and random texts, scoreboard.
module csv_cell_tokenizer_unit_tb;
   import csvt_pkg::*;

   localparam int unsigned MAX_COLS    = MAX_COLUMNS_DEFAULT;
   localparam logic [7:0]  COL_LIMIT   = (MAX_COLS - 1 > 255) ? 8'd255 : 8'(MAX_COLS - 1);
   localparam int unsigned PHASE_ITEMS = 160;
   localparam int unsigned N_PHASES    = 8;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned CYCLE_LIMIT = 600000;

   // Tokenizer state tracker and store of results still to come
   class tokenizer_scoreboard;
      logic [7:0]     line_end;
      quote_mode_type mode;
      logic [7:0]     column;
      logic           row_open;
      result_type     expected[$];
      int unsigned    errors;

      function new();
         line_end = LINE_END_RESET;
         mode     = MODE_UNQUOTED;
         column   = '0;
         row_open = 1'b0;
         errors   = 0;
      endfunction

      function void add_result(kind_type k, logic [7:0] d);
         result_type r;
         r.kind         = k;
         r.data_byte    = d;
         r.column_index = column;
         r.last_of_run  = 1'b0;
         expected.push_back(r);
      endfunction

      // byte seen outside quotes
      function void plain_byte(logic [7:0] b);
         if (b == CHAR_QUOTE) begin
            mode     = MODE_QUOTED;
            row_open = 1'b1;
         end else if (b == CHAR_COMMA) begin
            add_result(KIND_CELL_END, 8'h00);
            if (column < COL_LIMIT) column++;
            row_open = 1'b1;
         end else if (b == line_end) begin
            add_result(KIND_ROW_END, 8'h00);
            column   = '0;
            row_open = 1'b0;
         end else begin
            add_result(KIND_CHAR, b);
            row_open = 1'b1;
         end
      endfunction

      // accepted input item: work out the results it causes
      function void note_byte(logic [7:0] b, logic eot);
         int unsigned n_prior;
         result_type  r;
         n_prior = expected.size();
         case (mode)
            MODE_PENDING: begin
               if (b == CHAR_QUOTE) begin
                  add_result(KIND_CHAR, CHAR_QUOTE);
                  mode     = MODE_QUOTED;
                  row_open = 1'b1;
               end else begin
                  mode = MODE_UNQUOTED;
                  plain_byte(b);
               end
            end
            MODE_QUOTED: begin
               if (b == CHAR_QUOTE) mode = eot ? MODE_UNQUOTED : MODE_PENDING;
               else add_result(KIND_CHAR, b);
               row_open = 1'b1;
            end
            default: begin
               mode = MODE_UNQUOTED;
               plain_byte(b);
            end
         endcase
         // end of text closes an open row and starts afresh
         if (eot) begin
            if (row_open) add_result(KIND_ROW_END, 8'h00);
            mode     = MODE_UNQUOTED;
            column   = '0;
            row_open = 1'b0;
         end
         if (expected.size() > n_prior) begin
            r = expected.pop_back();
            r.last_of_run = 1'b1;
            expected.push_back(r);
         end
      endfunction

      // accepted result item against the oldest expectation
      function void check_result(kind_type k, logic [7:0] d, logic [7:0] c, logic l);
         result_type e;
         if (expected.size() == 0) begin
            $error("unexpected result: kind %0d data_byte %0d column_index %0d", k, d, c);
            errors++;
         end else begin
            e = expected.pop_front();
            if (e.kind !== k) begin
               $error("kind: expected %0d, actual %0d", e.kind, k);
               errors++;
            end
            if (e.data_byte !== d) begin
               $error("data_byte: expected %0d, actual %0d", e.data_byte, d);
               errors++;
            end
            if (e.column_index !== c) begin
               $error("column_index: expected %0d, actual %0d", e.column_index, c);
               errors++;
            end
            if (e.last_of_run !== l) begin
               $error("last_of_run: expected %0d, actual %0d", e.last_of_run, l);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = LINE_END_RESET;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   logic        quiet    = 1'b0;
   logic        hold_rsp = 1'b0;
   int unsigned sent     = 0;
   logic [7:0]  text_bytes[$];
   logic        text_ends[$];

   tokenizer_scoreboard sb = new();

   csv_cell_tokenizer_unit #(
      .MAX_COLUMNS (MAX_COLS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(kind_type'(rsp_tuser), rsp_tdata[7:0], rsp_tdata[15:8], rsp_tlast);
      end
   end

   // receiver: random stall bursts, calm stretches and one long hold-off
   initial begin
      int unsigned stall_left;
      int unsigned calm_left;
      stall_left = 0;
      calm_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end else if (quiet) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (calm_left > 0) begin
            rsp_tready <= 1'b1;
            calm_left--;
         end else begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  rsp_tready <= 1'b0;
                  stall_left = $urandom_range(0, 10);
               end
               2: begin
                  rsp_tready <= 1'b1;
                  calm_left = $urandom_range(20, 120);
               end
               default: rsp_tready <= 1'b1;
            endcase
         end
      end
   end

   // watchdog
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("csv_cell_tokenizer_unit_tb: FAIL");
      $finish;
   end

   // offer one byte until taken, then maybe leave a gap; called just after an edge
   task automatic send_byte(input logic [7:0] b, input logic eot, input logic gaps_on = 1'b0);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(b, eot);
      sent++;
      if (gaps_on && !quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // stop offering and wait until every expected result has come
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_line_end(input logic [7:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.line_end = v;
   endtask

   function automatic void push_byte(logic [7:0] b, logic eot = 1'b0);
      text_bytes.push_back(b);
      text_ends.push_back(eot);
   endfunction

   // byte with no special meaning under the current line end
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CHAR_QUOTE || c == CHAR_COMMA || c == sb.line_end);
      return c;
   endfunction

   function automatic void add_cell();
      int unsigned n;
      logic [7:0]  c;
      n = $urandom_range(0, 5);
      if ($urandom_range(0, 2) == 0) begin
         // quoted cell with doubled quotes, commas and line ends as data
         push_byte(CHAR_QUOTE);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
               0: begin
                  push_byte(CHAR_QUOTE);
                  push_byte(CHAR_QUOTE);
               end
               1: push_byte(CHAR_COMMA);
               2: push_byte(sb.line_end);
               default: begin
                  do c = 8'($urandom_range(0, 255));
                  while (c == CHAR_QUOTE);
                  push_byte(c);
               end
            endcase
         end
         push_byte(CHAR_QUOTE);
      end else begin
         for (int i = 0; i < n; i++) push_byte(plain_char());
      end
   endfunction

   // well-formed text: rows of cells, usually closed by end of text
   function automatic void build_text();
      int unsigned n_rows;
      int unsigned n_cells;
      logic        eot;
      n_rows = $urandom_range(1, 4);
      for (int r = 0; r < n_rows; r++) begin
         n_cells = $urandom_range(1, 5);
         for (int c = 0; c < n_cells; c++) begin
            if (c > 0) push_byte(CHAR_COMMA);
            add_cell();
         end
         if (r < n_rows - 1 || $urandom_range(0, 1) == 1) push_byte(sb.line_end);
      end
      if (text_bytes.size() == 0) push_byte(plain_char());
      eot = ($urandom_range(0, 7) != 0);
      void'(text_ends.pop_back());
      text_ends.push_back(eot);
   endfunction

   // noise: special bytes dense, ends of text anywhere
   function automatic void build_noise();
      int unsigned n;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: push_byte(CHAR_QUOTE, $urandom_range(0, 7) == 0);
            1: push_byte(CHAR_COMMA, $urandom_range(0, 7) == 0);
            2: push_byte(sb.line_end, $urandom_range(0, 7) == 0);
            default: push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         endcase
      end
   endfunction

   task automatic send_queued();
      logic gaps_on;
      gaps_on = !quiet && ($urandom_range(0, 3) != 0);
      while (text_bytes.size() != 0) begin
         send_byte(text_bytes.pop_front(), text_ends.pop_front(), gaps_on);
      end
   endtask

   // main sequence
   initial begin
      logic [7:0]  line_end_set[N_PHASES];
      logic [7:0]  le;
      logic        long_row_done;
      logic        pause_done;
      int unsigned goal;
      line_end_set = '{LINE_END_RESET, 8'd10, 8'h00, 8'hFF, CHAR_QUOTE, CHAR_COMMA,
                       8'h00, LINE_END_RESET};
      long_row_done = 1'b0;
      pause_done    = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: plain bytes and field extremes
      send_byte("a", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CHAR_COMMA, 1'b0);
      send_byte(LINE_END_RESET, 1'b0);
      // quoted comma and line end, doubled quote, pending quote then other byte
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte(CHAR_COMMA, 1'b0);
      send_byte(LINE_END_RESET, 1'b0);
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte("x", 1'b0);
      // quote at end of text inside quotes
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte("a", 1'b0);
      send_byte(CHAR_QUOTE, 1'b1);
      // end of text with open row, comma at end, closed row at end
      send_byte("b", 1'b1);
      send_byte(CHAR_COMMA, 1'b1);
      send_byte(LINE_END_RESET, 1'b1);
      // text ending inside quotes
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte("q", 1'b1);
      // pending quote then line end at end of text
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte(LINE_END_RESET, 1'b1);
      // empty quoted cell closed by end of text
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte(CHAR_QUOTE, 1'b1);

      // random phases, one line end setting each
      for (int p = 0; p < N_PHASES; p++) begin
         le = (p == 6) ? 8'($urandom_range(0, 255)) : line_end_set[p];
         write_line_end(le);
         if (p == N_PHASES - 1) quiet = 1'b1;
         if (p == 2) hold_rsp <= 1'b1;
         goal = sent + PHASE_ITEMS;
         while (sent < goal) begin
            if (p == 1 && !long_row_done) begin
               // row long enough to saturate the column index
               for (int i = 0; i < int'(COL_LIMIT) + 15; i++) push_byte(CHAR_COMMA);
               push_byte(plain_char(), 1'b1);
               long_row_done = 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
               build_noise();
            end else begin
               build_text();
            end
            send_queued();
            if (p == 3 && !pause_done && sent > goal - PHASE_ITEMS / 2) begin
               drain();
               pause_done = 1'b1;
            end
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.expected.size() == 0) begin
         $display("csv_cell_tokenizer_unit_tb: PASS");
      end else begin
         $display("csv_cell_tokenizer_unit_tb: FAIL");
      end
      $finish;
   end

endmodule

FILE: csv_cell_tokenizer_unit.f
rtl/csvt_pkg.sv
rtl/csvt_step.sv
rtl/csv_cell_tokenizer_unit.sv
tb/csv_cell_tokenizer_unit_tb.sv
